>>> hw/rtl/dms_pkg.sv
// dms_pkg: constants, types and twiddle tables for the dft magnitude spectrum block
// no dependencies; used by dft_magnitude_spectrum
package dms_pkg;

  localparam int FRAME_LEN = 128;
  localparam int TW_BITS   = 16;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int NUM_BINS  = FRAME_LEN / 2;
  localparam int BIN_W     = 6;
  localparam int SMP_W     = 16;
  localparam int TW_W      = TW_BITS + 1;
  localparam int ACC_W     = SMP_W + TW_W + IDX_W;
  localparam int SUM_W     = 24;
  localparam int SQ_W      = 2 * SUM_W;
  localparam int MAG_W     = 24;
  localparam int AMP_W     = 17;
  localparam int STEP_W    = 5;

  typedef logic signed [TW_W-1:0] tw_t;
  typedef tw_t tw_tab_t [FRAME_LEN];

  // control states, one-hot
  typedef enum logic [4:0] {
    S_FILL = 5'b00001,
    S_MAC  = 5'b00010,
    S_SQ   = 5'b00100,
    S_ROOT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;

  // horner taylor sine in q30, x in q30 radians up to pi/4
  function automatic longint unsigned oct_sin(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 5; i++) begin
      y = (x2 * t) >> 30;
      case (i)
        0: t = Q30_ONE - y / 64'd110;
        1: t = Q30_ONE - y / 64'd72;
        2: t = Q30_ONE - y / 64'd42;
        3: t = Q30_ONE - y / 64'd20;
        default: t = Q30_ONE - y / 64'd6;
      endcase
    end
    return (x * t) >> 30;
  endfunction

  // horner taylor cosine in q30
  function automatic longint unsigned oct_cos(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned y;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 6; i++) begin
      y = (x2 * t) >> 30;
      case (i)
        0: t = Q30_ONE - y / 64'd132;
        1: t = Q30_ONE - y / 64'd90;
        2: t = Q30_ONE - y / 64'd56;
        3: t = Q30_ONE - y / 64'd30;
        4: t = Q30_ONE - y / 64'd12;
        default: t = Q30_ONE - (y >> 1);
      endcase
    end
    return t;
  endfunction

  // round q30 half up to the twiddle format
  function automatic longint signed to_tw(input longint unsigned v);
    return longint'((v + (64'd1 << (30 - TW_BITS))) >> (31 - TW_BITS));
  endfunction

  // cosine (sel_sin = 0) or sine (sel_sin = 1) table over one turn
  function automatic tw_tab_t make_tab(input logic sel_sin);
    tw_tab_t         tab;
    longint unsigned p;
    longint unsigned r;
    longint unsigned x;
    longint unsigned s0;
    longint unsigned c0;
    longint signed   cs;
    longint signed   sn;
    longint signed   cv;
    longint signed   sv;
    int              q;
    for (int m = 0; m < FRAME_LEN; m++) begin
      p = (longint'(m) << 32) >> IDX_W;
      q = int'((p >> 30) & 64'd3);
      r = p & (Q30_ONE - 64'd1);
      if (r > (Q30_ONE >> 1)) begin
        x  = ((Q30_ONE - r) * TWO_PI_Q32) >> 34;
        c0 = oct_sin(x);
        s0 = oct_cos(x);
      end else begin
        x  = (r * TWO_PI_Q32) >> 34;
        s0 = oct_sin(x);
        c0 = oct_cos(x);
      end
      cs = to_tw(c0);
      sn = to_tw(s0);
      case (q)
        0: begin cv = cs;  sv = sn;  end
        1: begin cv = -sn; sv = cs;  end
        2: begin cv = -cs; sv = -sn; end
        default: begin cv = sn; sv = -cs; end
      endcase
      tab[m] = sel_sin ? tw_t'(sv) : tw_t'(cv);
    end
    return tab;
  endfunction

  localparam tw_tab_t COS_TAB = make_tab(1'b0);
  localparam tw_tab_t SIN_TAB = make_tab(1'b1);

endpackage

>>> hw/rtl/dms_ram.sv
// dms_ram: generic single-write, single-read ram with registered read data
// no dependencies
module dms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/dft_magnitude_spectrum.sv
// dft_magnitude_spectrum: direct dft of a real frame, per-bin sums and magnitude
// depends on dms_pkg and dms_ram
//
// Samples are taken one word per cycle until 128 are stored; during that time
// no result is produced. The last sample starts the transform, and the input
// stalls until all 64 bin words are delivered. Each bin goes through
// multiply-accumulate (one sample read from the frame ram per cycle, one cosine
// and one sine product), rescale and squaring, sum, a bit-pair square root,
// and a hand-off of the word that waits while the output stalls. The single
// sample read per cycle from the frame ram bounds the speed of the block.
module dft_magnitude_spectrum (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dms_pkg::SMP_W-1:0]       in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [dms_pkg::BIN_W-1:0]              out_bin_index,
  output logic signed [dms_pkg::SUM_W-1:0]       out_real_sum,
  output logic signed [dms_pkg::SUM_W-1:0]       out_imag_sum,
  output logic [dms_pkg::MAG_W-1:0]              out_magnitude,
  output logic [dms_pkg::AMP_W-1:0]              out_amplitude,
  output logic                                   out_last_bin
);
  import dms_pkg::*;

  state_t                   state_r;
  logic [IDX_W-1:0]         fill_r;
  logic [BIN_W-1:0]         k_r;
  logic [IDX_W-1:0]         iss_n_r;
  logic                     iss_on_r;
  logic [IDX_W-1:0]         m_r;
  logic [IDX_W-1:0]         d_m_r;
  logic                     d_vld_r;
  logic                     d_last_r;
  logic signed [ACC_W-1:0]  acc_re_r;
  logic signed [ACC_W-1:0]  acc_im_r;
  logic signed [SUM_W-1:0]  re_r;
  logic signed [SUM_W-1:0]  im_r;
  logic signed [SQ_W-1:0]   sq_re_r;
  logic signed [SQ_W-1:0]   sq_im_r;
  logic [SQ_W-1:0]          rem_r;
  logic [SQ_W-1:0]          res_r;
  logic [SQ_W-1:0]          bit_r;
  logic [STEP_W-1:0]        step_r;

  logic                     in_acc;
  logic                     out_acc;
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic signed [SMP_W-1:0]  ram_rdata;
  logic signed [SMP_W+TW_W-1:0] prod_re;
  logic signed [SMP_W+TW_W-1:0] prod_im;
  logic signed [SUM_W-1:0]  re_shift;
  logic signed [SUM_W-1:0]  im_shift;
  logic [SQ_W-1:0]          sq_sum;
  logic [SQ_W-1:0]          trial;

  assign in_stall  = (state_r != S_FILL);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);
  assign out_acc   = out_valid && !out_stall;
  assign ram_we    = in_acc;
  assign ram_raddr = iss_n_r;

  // frame store
  dms_ram #(
    .WIDTH (SMP_W),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (in_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // complex products and rescale by a floor shift
  assign prod_re  = ram_rdata * COS_TAB[d_m_r];
  assign prod_im  = ram_rdata * SIN_TAB[d_m_r];
  assign re_shift = acc_re_r[TW_BITS-1+SUM_W-1:TW_BITS-1];
  assign im_shift = acc_im_r[TW_BITS-1+SUM_W-1:TW_BITS-1];
  assign sq_sum   = {sq_re_r[SQ_W-3:0] + sq_im_r[SQ_W-3:0], 2'b00};
  assign trial    = res_r + bit_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FILL;
      fill_r   <= '0;
      k_r      <= '0;
      iss_on_r <= 1'b0;
      d_vld_r  <= 1'b0;
    end else begin
      case (state_r)
        S_FILL: begin
          if (in_acc) begin
            fill_r <= fill_r + 1'b1;
            if (fill_r == IDX_W'(FRAME_LEN - 1)) begin
              state_r  <= S_MAC;
              k_r      <= '0;
              iss_on_r <= 1'b1;
            end
          end
        end
        S_MAC: begin
          d_vld_r <= iss_on_r;
          if (iss_on_r && iss_n_r == IDX_W'(FRAME_LEN - 1)) begin
            iss_on_r <= 1'b0;
          end
          if (d_vld_r && d_last_r) begin
            state_r <= S_SQ;
            d_vld_r <= 1'b0;
          end
        end
        S_SQ: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (step_r != '0 && bit_r == SQ_W'(1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (k_r == BIN_W'(NUM_BINS - 1)) begin
              state_r <= S_FILL;
            end else begin
              k_r      <= k_r + 1'b1;
              state_r  <= S_MAC;
              iss_on_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_FILL;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // sample read issue, twiddle index steps by k
    if (iss_on_r && state_r == S_MAC) begin
      iss_n_r  <= iss_n_r + 1'b1;
      m_r      <= m_r + IDX_W'(k_r);
      d_m_r    <= m_r;
      d_last_r <= (iss_n_r == IDX_W'(FRAME_LEN - 1));
    end else if (state_r != S_MAC) begin
      iss_n_r  <= '0;
      m_r      <= '0;
      d_last_r <= 1'b0;
    end
    // accumulate
    if (state_r != S_MAC) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (d_vld_r) begin
      acc_re_r <= acc_re_r + ACC_W'(prod_re);
      acc_im_r <= acc_im_r + ACC_W'(prod_im);
    end
    // rescale and square
    if (state_r == S_SQ) begin
      re_r    <= re_shift;
      im_r    <= im_shift;
      sq_re_r <= re_shift * re_shift;
      sq_im_r <= im_shift * im_shift;
      step_r  <= '0;
    end
    // bit-pair square root
    if (state_r == S_ROOT) begin
      step_r <= step_r + 1'b1;
      if (step_r == '0) begin
        rem_r <= sq_sum;
        res_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
      end else begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  // result word
  assign out_bin_index = k_r;
  assign out_real_sum  = re_r;
  assign out_imag_sum  = im_r;
  assign out_magnitude = res_r[MAG_W-1:0];
  assign out_amplitude = res_r[MAG_W-1:IDX_W];
  assign out_last_bin  = (k_r == BIN_W'(NUM_BINS - 1));

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while results pending");
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_bin) |=> (state_r == S_FILL && fill_r == '0))
    else $error("frame end did not return to fill");
  a_fill_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && fill_r == IDX_W'(FRAME_LEN - 1)) |=> (state_r == S_MAC && k_r == '0))
    else $error("full frame did not start transform");

endmodule
